FILE: sv/gcne_pkg.sv
package gcne_pkg;

   localparam int unsigned COORD_W = 6;
   localparam int unsigned DIM_W = 7;
   localparam int unsigned NC_W = COORD_W + 1;
   localparam int unsigned HD_W = 2 * DIM_W;
   localparam int unsigned PYZ_W = HD_W + 1;
   localparam int unsigned IDX_W = 18;
   localparam int unsigned NUM_CAND = 27;
   localparam int unsigned CAND_W = $clog2(NUM_CAND);
   localparam int unsigned REG_W = 2;

   typedef enum logic [REG_W-1:0] {
      REG_GRID_WIDTH = 2'd0,
      REG_GRID_HEIGHT = 2'd1,
      REG_GRID_DEPTH = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      STEP_NONE = 2'd0,
      STEP_DEC = 2'd1,
      STEP_INC = 2'd2
   } step_dir_type;

   typedef struct packed {
      step_dir_type dx;
      step_dir_type dy;
      step_dir_type dz;
   } step_type;

   // self, x-1 group, x+1 group, y-1, y+1, z-1, z+1
   localparam step_type STEP_TABLE [NUM_CAND] = '{
      '{STEP_NONE, STEP_NONE, STEP_NONE},
      '{STEP_DEC, STEP_NONE, STEP_NONE}, '{STEP_DEC, STEP_DEC, STEP_NONE},
      '{STEP_DEC, STEP_DEC, STEP_DEC}, '{STEP_DEC, STEP_DEC, STEP_INC},
      '{STEP_DEC, STEP_INC, STEP_NONE}, '{STEP_DEC, STEP_INC, STEP_DEC},
      '{STEP_DEC, STEP_INC, STEP_INC}, '{STEP_DEC, STEP_NONE, STEP_DEC},
      '{STEP_DEC, STEP_NONE, STEP_INC},
      '{STEP_INC, STEP_NONE, STEP_NONE}, '{STEP_INC, STEP_DEC, STEP_NONE},
      '{STEP_INC, STEP_DEC, STEP_DEC}, '{STEP_INC, STEP_DEC, STEP_INC},
      '{STEP_INC, STEP_INC, STEP_NONE}, '{STEP_INC, STEP_INC, STEP_DEC},
      '{STEP_INC, STEP_INC, STEP_INC}, '{STEP_INC, STEP_NONE, STEP_DEC},
      '{STEP_INC, STEP_NONE, STEP_INC},
      '{STEP_NONE, STEP_DEC, STEP_NONE}, '{STEP_NONE, STEP_DEC, STEP_DEC},
      '{STEP_NONE, STEP_DEC, STEP_INC},
      '{STEP_NONE, STEP_INC, STEP_NONE}, '{STEP_NONE, STEP_INC, STEP_DEC},
      '{STEP_NONE, STEP_INC, STEP_INC},
      '{STEP_NONE, STEP_NONE, STEP_DEC}, '{STEP_NONE, STEP_NONE, STEP_INC}
   };

   typedef struct packed {
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic [DIM_W-1:0] d;
      logic [HD_W-1:0] hd;
   } dims_type;

   typedef struct packed {
      logic [CAND_W-1:0] cand;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic last;
      logic oog;
   } pick_type;

   // neighbour along one axis stays inside the grid
   function automatic logic step_ok(logic [COORD_W-1:0] coord, step_dir_type dir,
                                    logic [DIM_W-1:0] dim);
      logic ok;
      case (dir)
         STEP_NONE: ok = 1'b1;
         STEP_DEC: ok = (coord != '0);
         STEP_INC: ok = ((NC_W'(coord) + NC_W'(1)) < dim);
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic [NC_W-1:0] step_coord(logic [COORD_W-1:0] coord,
                                                  step_dir_type dir);
      logic [NC_W-1:0] nc;
      case (dir)
         STEP_NONE: nc = NC_W'(coord);
         STEP_DEC: nc = NC_W'(coord) - NC_W'(1);
         STEP_INC: nc = NC_W'(coord) + NC_W'(1);
         default: nc = NC_W'(coord);
      endcase
      return nc;
   endfunction

endpackage

FILE: sv/gcne_req_if.sv
interface gcne_req_if;
   logic valid;
   logic ready;
   logic [gcne_pkg::COORD_W-1:0] cell_x;
   logic [gcne_pkg::COORD_W-1:0] cell_y;
   logic [gcne_pkg::COORD_W-1:0] cell_z;

   modport source (output valid, output cell_x, output cell_y, output cell_z, input ready);
   modport sink (input valid, input cell_x, input cell_y, input cell_z, output ready);
endinterface

FILE: sv/gcne_rsp_if.sv
interface gcne_rsp_if;
   logic valid;
   logic ready;
   logic [gcne_pkg::IDX_W-1:0] neighbour_index;
   logic last_flag;
   logic out_of_grid;

   modport source (output valid, output neighbour_index, output last_flag,
                   output out_of_grid, input ready);
   modport sink (input valid, input neighbour_index, input last_flag,
                 input out_of_grid, output ready);
endinterface

FILE: sv/gcne_csr_if.sv
interface gcne_csr_if;
   logic valid;
   logic ready;
   logic [gcne_pkg::REG_W-1:0] index;
   logic [gcne_pkg::DIM_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/grid_cell_neighbour_enumerator_top.sv
// first response: the accepted request is registered in the sequencer, then passes index stages 2, 3 and 4
// throughput: one response per cycle while rsp_ch.ready is high, 1 to 27 responses per request
// the candidate sequencer accepts the next request in the cycle its last candidate leaves
// reset (synchronous, active high) empties the pipeline and sets all grid sizes to 64
module grid_cell_neighbour_enumerator_top #(
   parameter int MAX_DIM = 64
) (
   input logic clock,
   input logic reset,
   gcne_req_if.sink req_ch,
   gcne_rsp_if.source rsp_ch,
   gcne_csr_if.sink csr_ch
);

   gcne_pkg::dims_type dims;
   gcne_pkg::pick_type pick;
   logic pick_valid, pick_ready;

   gcne_csr #(.MAX_DIM(MAX_DIM)) u_csr (
      .clock(clock),
      .reset(reset),
      .csr_ch(csr_ch),
      .dims(dims)
   );

   gcne_seq u_seq (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .dims(dims),
      .pick_valid(pick_valid),
      .pick_ready(pick_ready),
      .pick(pick)
   );

   gcne_index u_index (
      .clock(clock),
      .reset(reset),
      .pick_valid(pick_valid),
      .pick_ready(pick_ready),
      .pick(pick),
      .dims(dims),
      .rsp_ch(rsp_ch)
   );

endmodule

FILE: sv/gcne_csr.sv
module gcne_csr #(
   parameter int MAX_DIM = 64
) (
   input logic clock,
   input logic reset,
   gcne_csr_if.sink csr_ch,
   output gcne_pkg::dims_type dims
);

   localparam logic [gcne_pkg::DIM_W-1:0] DIM_CAP =
      (MAX_DIM > 127) ? 7'd127 : gcne_pkg::DIM_W'(MAX_DIM);
   localparam logic [gcne_pkg::DIM_W-1:0] DIM_RESET = 7'd64;

   logic [gcne_pkg::DIM_W-1:0] width_ff, height_ff, depth_ff;
   logic [gcne_pkg::DIM_W-1:0] w_cl, h_cl, d_cl;
   logic [gcne_pkg::HD_W-1:0] hd_ff, hd_in;
   logic wr;

   assign csr_ch.ready = 1'b1;
   assign wr = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= DIM_RESET;
         height_ff <= DIM_RESET;
         depth_ff <= DIM_RESET;
      end else if (wr) begin
         case (gcne_pkg::reg_index_type'(csr_ch.index))
            gcne_pkg::REG_GRID_WIDTH: width_ff <= csr_ch.data;
            gcne_pkg::REG_GRID_HEIGHT: height_ff <= csr_ch.data;
            gcne_pkg::REG_GRID_DEPTH: depth_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // saturate oversized dimensions
   assign w_cl = (width_ff > DIM_CAP) ? DIM_CAP : width_ff;
   assign h_cl = (height_ff > DIM_CAP) ? DIM_CAP : height_ff;
   assign d_cl = (depth_ff > DIM_CAP) ? DIM_CAP : depth_ff;

   // plane size, ready well before the first request reaches the multiply stage
   assign hd_in = gcne_pkg::HD_W'(h_cl) * gcne_pkg::HD_W'(d_cl);

   always_ff @(posedge clock) begin
      hd_ff <= hd_in;
   end

   assign dims.w = w_cl;
   assign dims.h = h_cl;
   assign dims.d = d_cl;
   assign dims.hd = hd_ff;

endmodule

FILE: sv/gcne_seq.sv
module gcne_seq (
   input logic clock,
   input logic reset,
   gcne_req_if.sink req_ch,
   input gcne_pkg::dims_type dims,
   output logic pick_valid,
   input logic pick_ready,
   output gcne_pkg::pick_type pick
);

   logic busy_ff;
   logic [gcne_pkg::NUM_CAND-1:0] mask_ff, mask_in, rest;
   logic [gcne_pkg::COORD_W-1:0] x_ff, y_ff, z_ff;
   logic oog_ff, oog_in;
   logic [gcne_pkg::CAND_W-1:0] cand;
   logic last, accept, emit;

   assign oog_in = (gcne_pkg::DIM_W'(req_ch.cell_x) >= dims.w)
                || (gcne_pkg::DIM_W'(req_ch.cell_y) >= dims.h)
                || (gcne_pkg::DIM_W'(req_ch.cell_z) >= dims.d);

   always_comb begin
      for (int c = 0; c < gcne_pkg::NUM_CAND; c++) begin
         mask_in[c] = gcne_pkg::step_ok(req_ch.cell_x, gcne_pkg::STEP_TABLE[c].dx, dims.w)
                   && gcne_pkg::step_ok(req_ch.cell_y, gcne_pkg::STEP_TABLE[c].dy, dims.h)
                   && gcne_pkg::step_ok(req_ch.cell_z, gcne_pkg::STEP_TABLE[c].dz, dims.d);
      end
      // outside the grid: a single flagged response
      if (oog_in) begin
         mask_in = gcne_pkg::NUM_CAND'(1);
      end
   end

   // lowest remaining candidate goes next
   always_comb begin
      cand = '0;
      for (int c = gcne_pkg::NUM_CAND - 1; c >= 0; c--) begin
         if (mask_ff[c]) begin
            cand = gcne_pkg::CAND_W'(c);
         end
      end
   end

   assign rest = mask_ff & (mask_ff - gcne_pkg::NUM_CAND'(1));
   assign last = (rest == '0);
   assign emit = busy_ff && pick_ready;
   assign req_ch.ready = !busy_ff || (pick_ready && last);
   assign accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (emit && last) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mask_ff <= mask_in;
         x_ff <= req_ch.cell_x;
         y_ff <= req_ch.cell_y;
         z_ff <= req_ch.cell_z;
         oog_ff <= oog_in;
      end else if (emit) begin
         mask_ff <= rest;
      end
   end

   assign pick_valid = busy_ff;
   assign pick.cand = cand;
   assign pick.x = x_ff;
   assign pick.y = y_ff;
   assign pick.z = z_ff;
   assign pick.last = last;
   assign pick.oog = oog_ff;

endmodule

FILE: sv/gcne_index.sv
module gcne_index (
   input logic clock,
   input logic reset,
   input logic pick_valid,
   output logic pick_ready,
   input gcne_pkg::pick_type pick,
   input gcne_pkg::dims_type dims,
   gcne_rsp_if.source rsp_ch
);

   logic en2, en3, en4;
   logic v2_ff, v3_ff, v4_ff;

   logic [gcne_pkg::NC_W-1:0] nx2_ff, ny2_ff, nz2_ff, nx2_in, ny2_in, nz2_in;
   logic last2_ff, oog2_ff;

   logic [gcne_pkg::IDX_W-1:0] px3_ff;
   logic [gcne_pkg::NC_W+gcne_pkg::HD_W-1:0] px_full;
   logic [gcne_pkg::PYZ_W-1:0] pyz3_ff, pyz3_in;
   logic last3_ff, oog3_ff;

   logic [gcne_pkg::IDX_W-1:0] idx4_ff, idx4_in;
   logic last4_ff, oog4_ff;

   assign en4 = !v4_ff || rsp_ch.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign pick_ready = en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en2) v2_ff <= pick_valid;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // stage 2: neighbour coordinates, forced to zero outside the grid
   always_comb begin
      nx2_in = gcne_pkg::step_coord(pick.x, gcne_pkg::STEP_TABLE[pick.cand].dx);
      ny2_in = gcne_pkg::step_coord(pick.y, gcne_pkg::STEP_TABLE[pick.cand].dy);
      nz2_in = gcne_pkg::step_coord(pick.z, gcne_pkg::STEP_TABLE[pick.cand].dz);
      if (pick.oog) begin
         nx2_in = '0;
         ny2_in = '0;
         nz2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         nx2_ff <= nx2_in;
         ny2_ff <= ny2_in;
         nz2_ff <= nz2_in;
         last2_ff <= pick.last;
         oog2_ff <= pick.oog;
      end
   end

   // stage 3: x * plane and y * depth + z
   assign px_full = (gcne_pkg::NC_W + gcne_pkg::HD_W)'(nx2_ff)
                  * (gcne_pkg::NC_W + gcne_pkg::HD_W)'(dims.hd);
   assign pyz3_in = gcne_pkg::PYZ_W'(ny2_ff) * gcne_pkg::PYZ_W'(dims.d)
                  + gcne_pkg::PYZ_W'(nz2_ff);

   always_ff @(posedge clock) begin
      if (en3) begin
         px3_ff <= px_full[gcne_pkg::IDX_W-1:0];
         pyz3_ff <= pyz3_in;
         last3_ff <= last2_ff;
         oog3_ff <= oog2_ff;
      end
   end

   // stage 4: final sum into the output register
   assign idx4_in = px3_ff + gcne_pkg::IDX_W'(pyz3_ff);

   always_ff @(posedge clock) begin
      if (en4) begin
         idx4_ff <= idx4_in;
         last4_ff <= last3_ff;
         oog4_ff <= oog3_ff;
      end
   end

   assign rsp_ch.valid = v4_ff;
   assign rsp_ch.neighbour_index = idx4_ff;
   assign rsp_ch.last_flag = last4_ff;
   assign rsp_ch.out_of_grid = oog4_ff;

endmodule

FILE: sv/gcne_checker.sv
module gcne_checker (
   input logic clock,
   input logic reset,
   gcne_rsp_if.source rsp_ch
);

   // out of grid response is a lone zero index
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.out_of_grid |-> rsp_ch.last_flag && rsp_ch.neighbour_index == '0)
      else $error("out of grid response not a single zero index");

   assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.neighbour_index)
         && $stable(rsp_ch.last_flag) && $stable(rsp_ch.out_of_grid))
      else $error("stalled response changed");

endmodule

bind grid_cell_neighbour_enumerator_top gcne_checker u_chk (
   .clock(clock),
   .reset(reset),
   .rsp_ch(rsp_ch)
);
